[hw/rtl/wsfu_pkg.sv]
// ----------------------------------------------------------------------------
// wsfu_pkg
// Types and constants shared by the frame unmasker modules.
// ----------------------------------------------------------------------------
package wsfu_pkg;

  localparam logic [6:0] LEN_CODE_MASK  = 7'h7F;
  localparam logic [6:0] LEN_CODE_SHORT = 7'd125;
  localparam logic [6:0] LEN_CODE_16    = 7'd126;
  localparam logic [6:0] LEN_CODE_64    = 7'd127;

  localparam logic [3:0] EXT_BYTES_16   = 4'd2;
  localparam logic [3:0] EXT_BYTES_64   = 4'd8;
  localparam logic [3:0] MASK_BYTES     = 4'd4;

  localparam logic [3:0] HDR_SIZE_NONE  = 4'd0;
  localparam logic [3:0] HDR_SIZE_SHORT = 4'd6;
  localparam logic [3:0] HDR_SIZE_16    = 4'd8;
  localparam logic [3:0] HDR_SIZE_64    = 4'd14;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic STATUS_COMPLETE  = 1'b0;
  localparam logic STATUS_TOO_SHORT = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified input item: an unmasked byte, a status, or both.
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic       has_stat;
    logic       status;
    logic [3:0] hdr_size;
  } wsfu_op_t;

endpackage

[hw/rtl/wsfu_in_if.sv]
// ----------------------------------------------------------------------------
// wsfu_in_if
// Input byte channel: one buffer byte per transfer, flag on the final one.
// ----------------------------------------------------------------------------
interface wsfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[hw/rtl/wsfu_out_if.sv]
// ----------------------------------------------------------------------------
// wsfu_out_if
// Result channel: unmasked payload bytes and end of buffer status.
// ----------------------------------------------------------------------------
interface wsfu_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic       status;
  logic [3:0] header_size;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output status,
                  output header_size, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input header_size, input last, output ready);
endinterface

[hw/rtl/wsfu_parser.sv]
// ----------------------------------------------------------------------------
// wsfu_parser
// Front end: walks the frame header, unmasks payload bytes, flags end of buffer.
// ----------------------------------------------------------------------------
module wsfu_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  wsfu_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              q_push,
  output wsfu_pkg::wsfu_op_t q_op
);
  import wsfu_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_LEN   = 3'd1,
    PH_EXT   = 3'd2,
    PH_MASK  = 3'd3,
    PH_PAY   = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [6:0]             len_code_r, len_code_nxt;
  logic [LENGTH_BITS-1:0] pay_len_r, pay_len_nxt;
  logic [3:0][7:0]        mask_r, mask_nxt;
  logic [LENGTH_BITS-1:0] pay_cnt_r, pay_cnt_nxt;

  logic       accept;
  logic [6:0] code;
  logic [3:0] cnt_inc;
  logic [3:0] ext_need;
  wsfu_op_t   op;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign code        = in_ch.data_byte[6:0] & LEN_CODE_MASK;
  assign cnt_inc     = hdr_cnt_r + 4'd1;
  assign ext_need    = (len_code_r == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    len_code_nxt = len_code_r;
    pay_len_nxt  = pay_len_r;
    mask_nxt     = mask_r;
    pay_cnt_nxt  = pay_cnt_r;
    op           = '0;

    unique case (phase_r)
      PH_FIRST: begin
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_code_nxt = code;
        hdr_cnt_nxt  = '0;
        if (code <= LEN_CODE_SHORT) begin
          pay_len_nxt = LENGTH_BITS'(code);
          phase_nxt   = PH_MASK;
        end else begin
          pay_len_nxt = '0;
          phase_nxt   = PH_EXT;
        end
      end
      PH_EXT: begin
        // saturate once the value cannot take another byte
        if (|pay_len_r[LENGTH_BITS-1 -: 8]) begin
          pay_len_nxt = '1;
        end else begin
          pay_len_nxt = {pay_len_r[LENGTH_BITS-9:0], in_ch.data_byte};
        end
        hdr_cnt_nxt = cnt_inc;
        if (cnt_inc >= ext_need) begin
          hdr_cnt_nxt = '0;
          phase_nxt   = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_nxt    = {mask_r[2:0], in_ch.data_byte};
        hdr_cnt_nxt = cnt_inc;
        if (cnt_inc >= MASK_BYTES) begin
          hdr_cnt_nxt = '0;
          pay_cnt_nxt = '0;
          phase_nxt   = (pay_len_r == '0) ? PH_DONE : PH_PAY;
        end
      end
      PH_PAY: begin
        op.has_pay  = 1'b1;
        op.pay_byte = in_ch.data_byte ^ mask_r[2'd3 - pay_cnt_r[1:0]];
        pay_cnt_nxt = pay_cnt_r + LENGTH_BITS'(1);
        if (pay_cnt_nxt >= pay_len_r) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (phase_nxt == PH_FIRST || phase_nxt == PH_LEN) begin
      op.hdr_size = HDR_SIZE_NONE;
    end else if (len_code_nxt == LEN_CODE_16) begin
      op.hdr_size = HDR_SIZE_16;
    end else if (len_code_nxt == LEN_CODE_64) begin
      op.hdr_size = HDR_SIZE_64;
    end else begin
      op.hdr_size = HDR_SIZE_SHORT;
    end

    if (in_ch.end_of_buffer) begin
      op.has_stat = 1'b1;
      op.status   = (phase_nxt == PH_DONE) ? STATUS_COMPLETE : STATUS_TOO_SHORT;
    end
  end

  assign q_push = accept && (op.has_pay || op.has_stat);
  assign q_op   = op;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_ch.end_of_buffer)) begin
      phase_r    <= PH_FIRST;
      hdr_cnt_r  <= '0;
      len_code_r <= '0;
      pay_len_r  <= '0;
      mask_r     <= '0;
      pay_cnt_r  <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      len_code_r <= len_code_nxt;
      pay_len_r  <= pay_len_nxt;
      mask_r     <= mask_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
    end
  end

endmodule

[hw/rtl/wsfu_queue.sv]
// ----------------------------------------------------------------------------
// wsfu_queue
// Short register queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module wsfu_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  wsfu_pkg::wsfu_op_t         push_op,
  output logic                       full,
  input  logic                       pop,
  output wsfu_pkg::wsfu_op_t         pop_op,
  output logic                       empty,
  output logic [wsfu_pkg::QLVL_W-1:0] level
);
  import wsfu_pkg::*;

  wsfu_op_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QLVL_W-1:0]   level_r, level_nxt;

  assign full   = (level_r == QLVL_W'(QUEUE_DEPTH));
  assign empty  = (level_r == '0);
  assign level  = level_r;
  assign pop_op = slot_r[rd_ptr_r];

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QLVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QLVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

[hw/rtl/wsfu_emitter.sv]
// ----------------------------------------------------------------------------
// wsfu_emitter
// Back end: turns queued items into results behind an output register.
// ----------------------------------------------------------------------------
module wsfu_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  wsfu_pkg::wsfu_op_t q_op,
  output logic               q_pop,
  output logic               pend_stat,
  wsfu_out_if.source         out_ch
);
  import wsfu_pkg::*;

  logic       valid_r, valid_nxt;
  logic       pend_r, pend_nxt;
  logic       pend_status_r, pend_status_nxt;
  logic [3:0] pend_hs_r, pend_hs_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       status_r, status_nxt;
  logic [3:0] hs_r, hs_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt       = valid_r;
    pend_nxt        = pend_r;
    pend_status_nxt = pend_status_r;
    pend_hs_nxt     = pend_hs_r;
    kind_nxt        = kind_r;
    byte_nxt        = byte_r;
    status_nxt      = status_r;
    hs_nxt          = hs_r;
    last_nxt        = last_r;
    q_pop           = 1'b0;
    if (load) begin
      priority if (pend_r) begin
        // second result of an item: the status after its payload byte
        valid_nxt  = 1'b1;
        pend_nxt   = 1'b0;
        kind_nxt   = KIND_STATUS;
        byte_nxt   = '0;
        status_nxt = pend_status_r;
        hs_nxt     = pend_hs_r;
        last_nxt   = 1'b1;
      end else if (!q_empty) begin
        q_pop     = 1'b1;
        valid_nxt = 1'b1;
        hs_nxt    = q_op.hdr_size;
        if (q_op.has_pay) begin
          kind_nxt        = KIND_PAYLOAD;
          byte_nxt        = q_op.pay_byte;
          status_nxt      = STATUS_COMPLETE;
          last_nxt        = !q_op.has_stat;
          pend_nxt        = q_op.has_stat;
          pend_status_nxt = q_op.status;
          pend_hs_nxt     = q_op.hdr_size;
        end else begin
          kind_nxt   = KIND_STATUS;
          byte_nxt   = '0;
          status_nxt = q_op.status;
          last_nxt   = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_hs_r     <= pend_hs_nxt;
    kind_r        <= kind_nxt;
    byte_r        <= byte_nxt;
    status_r      <= status_nxt;
    hs_r          <= hs_nxt;
    last_r        <= last_nxt;
  end

  assign pend_stat           = pend_r;
  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.payload_byte = byte_r;
  assign out_ch.status       = status_r;
  assign out_ch.header_size  = hs_r;
  assign out_ch.last         = last_r;

endmodule

[hw/rtl/websocket_frame_unmasker.sv]
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Parses one client WebSocket frame per buffer and unmasks its payload.
// ----------------------------------------------------------------------------
// in_ch carries the received buffer one byte per transfer, end_of_buffer
// high on the final byte. out_ch returns one result per payload byte
// (kind 0, XORed with the mask) and one status per buffer (kind 1) on the
// final byte; last marks the final result of each input byte.
// Each result passes through a queue entry and then the output register
// before it is valid on out_ch.
// Throughput: one byte per cycle while the queue has room; a final byte
// that is also a payload byte gives two results, the payload then the status.
// The parser feeds a four-entry queue; the output stage drains it through
// one output register, so in_ch keeps taking bytes while a result waits.
// A receiver stall fills the queue, then in_ch.ready drops until an entry
// leaves it.
// Reset clears the parser, the queue and the output register; after the
// final byte of a buffer the parser starts again at a new frame.
// LENGTH_BITS sets the width of the length and payload counters; longer
// extended lengths saturate.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  wsfu_in_if.sink    in_ch,
  wsfu_out_if.source out_ch
);
  import wsfu_pkg::*;

  logic              q_push, q_pop, q_full, q_empty, pend_stat;
  wsfu_op_t          push_op, pop_op;
  logic [QLVL_W-1:0] q_level;

  wsfu_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (push_op)
  );

  wsfu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty),
    .level   (q_level)
  );

  wsfu_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_op      (pop_op),
    .q_pop     (q_pop),
    .pend_stat (pend_stat),
    .out_ch    (out_ch)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= QLVL_W'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pend_stat |-> (out_ch.valid && out_ch.kind == KIND_PAYLOAD && !out_ch.last))
    else $error("pending status without its payload result on show");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !q_pop) |=> ($past(q_level) == q_level))
    else $error("queue level moved while full and not read");

endmodule

[sim/tb_websocket_frame_unmasker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_unmasker
// Sends received buffers byte by byte: directed frames for the header forms
// and corner cases, then random well-formed, truncated and noise buffers
// under three idling mixes. A built-in frame parser predicts every unmasked
// byte and end of buffer status, and a checker compares each result transfer.
// ----------------------------------------------------------------------------
module tb_websocket_frame_unmasker;
  import wsfu_pkg::*;

  localparam int LEN_BITS       = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum logic [2:0] {
    PH_FIRST, PH_LENGTH, PH_EXT_LEN, PH_MASK_KEY, PH_PAYLOAD, PH_DONE
  } parse_phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       status;
    logic [3:0] header_size;
    logic       last;
  } frame_result_t;

  logic clk;
  logic rst_n;

  wsfu_in_if  in_if ();
  wsfu_out_if out_if ();

  websocket_frame_unmasker #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  parse_phase_e          parse_phase;
  logic [3:0]            hdr_count;
  logic [6:0]            len_code;
  logic [LEN_BITS-1:0]   frame_len;
  logic [31:0]           mask_key;
  logic [LEN_BITS-1:0]   unmasked_count;

  frame_result_t expected_results[$];
  logic [7:0]    buffer_bytes[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int error_count;
  int bytes_sent;
  int buffers_sent;
  int payload_results;
  int status_results;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [3:0] header_size_now();
    if (parse_phase == PH_FIRST || parse_phase == PH_LENGTH) return HDR_SIZE_NONE;
    if (len_code == LEN_CODE_16) return HDR_SIZE_16;
    if (len_code == LEN_CODE_64) return HDR_SIZE_64;
    return HDR_SIZE_SHORT;
  endfunction

  function automatic void clear_parser();
    parse_phase    = PH_FIRST;
    hdr_count      = '0;
    len_code       = '0;
    frame_len      = '0;
    mask_key       = '0;
    unmasked_count = '0;
  endfunction

  function automatic void predict_unmask(logic [7:0] b, logic eob);
    frame_result_t       produced[$];
    frame_result_t       r;
    logic [3:0]          need;
    logic [LEN_BITS-1:0] len_max;
    int                  sel;
    len_max = '1;
    case (parse_phase)
      PH_FIRST: parse_phase = PH_LENGTH;
      PH_LENGTH: begin
        len_code  = b[6:0] & LEN_CODE_MASK;
        hdr_count = '0;
        if (len_code <= LEN_CODE_SHORT) begin
          frame_len   = LEN_BITS'(len_code);
          parse_phase = PH_MASK_KEY;
        end else begin
          frame_len   = '0;
          parse_phase = PH_EXT_LEN;
        end
      end
      PH_EXT_LEN: begin
        need = (len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
        if (frame_len > (len_max >> 8)) frame_len = len_max;
        else frame_len = (frame_len << 8) | LEN_BITS'(b);
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= need) begin
          hdr_count   = '0;
          parse_phase = PH_MASK_KEY;
        end
      end
      PH_MASK_KEY: begin
        mask_key  = {mask_key[23:0], b};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= MASK_BYTES) begin
          hdr_count      = '0;
          unmasked_count = '0;
          parse_phase    = (frame_len == '0) ? PH_DONE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sel = 3 - int'(unmasked_count[1:0]);
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b ^ mask_key[sel*8 +: 8];
        r.status       = STATUS_COMPLETE;
        r.header_size  = header_size_now();
        r.last         = 1'b0;
        produced.push_back(r);
        unmasked_count = unmasked_count + 1'b1;
        if (unmasked_count >= frame_len) parse_phase = PH_DONE;
      end
      default: ;
    endcase
    if (eob) begin
      r.kind         = KIND_STATUS;
      r.payload_byte = 8'h00;
      r.status       = (parse_phase == PH_DONE) ? STATUS_COMPLETE : STATUS_TOO_SHORT;
      r.header_size  = header_size_now();
      r.last         = 1'b0;
      produced.push_back(r);
      clear_parser();
    end
    if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
    foreach (produced[i]) expected_results.push_back(produced[i]);
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("%0t: MISMATCH %s got 0x%02h expected 0x%02h", $realtime, field, got, want);
    error_count++;
  endtask

  task automatic send_byte(logic [7:0] b, logic eob);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.end_of_buffer <= eob;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_unmask(b, eob);
    bytes_sent++;
  endtask

  task automatic send_buffer();
    foreach (buffer_bytes[i]) send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
    buffers_sent++;
  endtask

  task automatic wait_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_single_byte_buffer();
    buffer_bytes = '{8'hFF};
    send_buffer();
  endtask

  task automatic test_empty_payload_frame();
    // mask bit set in the length byte, zero length, one byte past the frame
    buffer_bytes = '{8'h81, 8'h80, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h37};
    send_buffer();
  endtask

  task automatic test_extended16_frame();
    buffer_bytes = '{8'h00, 8'hFE, 8'h00, 8'h01, 8'h80, 8'h01, 8'h02, 8'h03, 8'hFF};
    send_buffer();
  endtask

  task automatic test_truncated_extended64();
    buffer_bytes = '{8'h82, 8'h7F, 8'hFF, 8'hFF};
    send_buffer();
  endtask

  task automatic test_random_buffers(int tx_pct, int rx_pct, int target);
    int          counted;
    int          form;
    int          npay;
    logic [63:0] len64;
    logic [6:0]  code;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    counted     = 0;
    while (counted < target) begin
      buffer_bytes.delete();
      if ($urandom_range(15) == 0) begin
        repeat ($urandom_range(1, 10)) buffer_bytes.push_back(8'($urandom));
        counted += buffer_bytes.size();
      end else begin
        form = $urandom_range(9);
        if (form <= 5) begin
          len64 = ($urandom_range(3) == 0) ? 64'($urandom_range(125))
                                           : 64'($urandom_range(8));
          code  = len64[6:0];
        end else if (form <= 7) begin
          len64 = ($urandom_range(3) == 0) ? 64'($urandom_range(65535))
                                           : 64'($urandom_range(24));
          code  = LEN_CODE_16;
        end else begin
          len64 = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(24));
          code  = LEN_CODE_64;
        end
        buffer_bytes.push_back(8'($urandom));
        buffer_bytes.push_back({1'($urandom), code});
        if (code == LEN_CODE_16) begin
          buffer_bytes.push_back(len64[15:8]);
          buffer_bytes.push_back(len64[7:0]);
        end else if (code == LEN_CODE_64) begin
          for (int i = 7; i >= 0; i--) buffer_bytes.push_back(len64[i*8 +: 8]);
        end
        repeat (4) buffer_bytes.push_back(8'($urandom));
        npay = (len64 <= 130) ? int'(len64) : int'($urandom_range(1, 40));
        repeat (npay) buffer_bytes.push_back(8'($urandom));
        counted += buffer_bytes.size();
        if ($urandom_range(7) == 0) begin
          buffer_bytes = buffer_bytes[0:$urandom_range(buffer_bytes.size() - 1)];
        end else begin
          repeat ($urandom_range(2)) buffer_bytes.push_back(8'($urandom));
        end
      end
      send_buffer();
    end
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {7'd0, out_if.kind}, 8'h00);
      end else begin
        want = expected_results.pop_front();
        if (out_if.kind !== want.kind)
          report_mismatch("kind", {7'd0, out_if.kind}, {7'd0, want.kind});
        if (out_if.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", out_if.payload_byte, want.payload_byte);
        if (out_if.status !== want.status)
          report_mismatch("status", {7'd0, out_if.status}, {7'd0, want.status});
        if (out_if.header_size !== want.header_size)
          report_mismatch("header_size", {4'd0, out_if.header_size}, {4'd0, want.header_size});
        if (out_if.last !== want.last)
          report_mismatch("last", {7'd0, out_if.last}, {7'd0, want.last});
        if (want.kind == KIND_STATUS) status_results++;
        else payload_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = 8'h00;
    in_if.end_of_buffer = 1'b0;
    out_if.ready        = 1'b0;
    tx_idle_pct         = 7;
    rx_idle_pct         = 56;
    error_count         = 0;
    bytes_sent          = 0;
    buffers_sent        = 0;
    payload_results     = 0;
    status_results      = 0;
    quiet_cycles        = 0;
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_byte_buffer();
    test_empty_payload_frame();
    test_extended16_frame();
    test_truncated_extended64();
    test_random_buffers(7, 56, 130);
    wait_until_drained();
    test_random_buffers(56, 7, 130);
    wait_until_drained();
    test_random_buffers(0, 0, 130);

    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers (short, 16-bit and 64-bit lengths,",
             bytes_sent, buffers_sent);
    $display("truncated and noise); checked %0d unmasked bytes and %0d statuses",
             payload_results, status_results);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[websocket_frame_unmasker.f]
hw/rtl/wsfu_pkg.sv
hw/rtl/wsfu_in_if.sv
hw/rtl/wsfu_out_if.sv
hw/rtl/wsfu_parser.sv
hw/rtl/wsfu_queue.sv
hw/rtl/wsfu_emitter.sv
hw/rtl/websocket_frame_unmasker.sv
sim/tb_websocket_frame_unmasker.sv
